@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// These macros wrap concurrent assertions on clk, with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// This checks that a property holds at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// This checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rpg_pkg.sv @@
// ----------------------------------------------------------------------------
// rpg_pkg
// Types, constants, microcode and helper functions for the permutation
// generator.
// ----------------------------------------------------------------------------
package rpg_pkg;

    localparam int MAX_COUNT  = 1024;
    localparam int IDX_W      = $clog2(MAX_COUNT);
    localparam int CNT_W      = $clog2(MAX_COUNT + 1);
    localparam int RNG_W      = 64;
    localparam int BIT_CNT_W  = $clog2(RNG_W);
    localparam int UPC_W      = 4;

    localparam logic [RNG_W-1:0] RNG_SEED = 64'h9e37_79b9_7f4a_7c15;
    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 7;
    localparam int SHIFT_C = 17;

    typedef enum logic
    {
        REQ_GENERATE = 1'b0,
        REQ_READ     = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        req_t             req_type;
        logic [IDX_W-1:0] position;
    } in_item_t;

    typedef struct packed
    {
        logic [IDX_W-1:0] entry_value;
        status_t          status;
    } out_item_t;

    typedef enum logic [UPC_W-1:0]
    {
        UPC_IDLE      = 4'd0,
        UPC_DISPATCH  = 4'd1,
        UPC_GEN_INIT  = 4'd2,
        UPC_FILL      = 4'd3,
        UPC_SHUF_INIT = 4'd4,
        UPC_RNG       = 4'd5,
        UPC_DIV       = 4'd6,
        UPC_READ_AB   = 4'd7,
        UPC_WRITE_I   = 4'd8,
        UPC_WRITE_J   = 4'd9,
        UPC_GEN_DONE  = 4'd10,
        UPC_RD_ISSUE  = 4'd11,
        UPC_RD_OUT    = 4'd12
    } upc_t;

    typedef enum logic [3:0]
    {
        OP_ACCEPT,
        OP_NOP,
        OP_GEN_INIT,
        OP_FILL,
        OP_SHUF_INIT,
        OP_RNG,
        OP_DIV,
        OP_READ_AB,
        OP_WRITE_I,
        OP_WRITE_J,
        OP_GEN_DONE,
        OP_RD_ISSUE,
        OP_RD_OUT
    } micro_op_t;

    typedef enum logic [2:0]
    {
        COND_ALWAYS,
        COND_NOT_ACCEPT,
        COND_IS_READ,
        COND_FILL_MORE,
        COND_DIV_MORE,
        COND_SHUF_MORE
    } cond_t;

    typedef struct packed
    {
        micro_op_t op;
        cond_t     cond;
        upc_t      target;
    } ctrl_word_t;

    typedef struct packed
    {
        logic accept;
        logic is_read;
        logic fill_more;
        logic div_more;
        logic shuf_more;
    } cond_flags_t;

    typedef struct packed
    {
        micro_op_t op;
        upc_t      upc;
    } seq_ctrl_t;

    function automatic ctrl_word_t ucode_rom(input upc_t addr);
        ctrl_word_t word;
        case (addr)
            UPC_IDLE:      word = '{OP_ACCEPT,    COND_NOT_ACCEPT, UPC_IDLE};
            UPC_DISPATCH:  word = '{OP_NOP,       COND_IS_READ,    UPC_RD_ISSUE};
            UPC_GEN_INIT:  word = '{OP_GEN_INIT,  COND_ALWAYS,     UPC_FILL};
            UPC_FILL:      word = '{OP_FILL,      COND_FILL_MORE,  UPC_FILL};
            UPC_SHUF_INIT: word = '{OP_SHUF_INIT, COND_ALWAYS,     UPC_RNG};
            UPC_RNG:       word = '{OP_RNG,       COND_ALWAYS,     UPC_DIV};
            UPC_DIV:       word = '{OP_DIV,       COND_DIV_MORE,   UPC_DIV};
            UPC_READ_AB:   word = '{OP_READ_AB,   COND_ALWAYS,     UPC_WRITE_I};
            UPC_WRITE_I:   word = '{OP_WRITE_I,   COND_ALWAYS,     UPC_WRITE_J};
            UPC_WRITE_J:   word = '{OP_WRITE_J,   COND_SHUF_MORE,  UPC_RNG};
            UPC_GEN_DONE:  word = '{OP_GEN_DONE,  COND_ALWAYS,     UPC_IDLE};
            UPC_RD_ISSUE:  word = '{OP_RD_ISSUE,  COND_ALWAYS,     UPC_RD_OUT};
            UPC_RD_OUT:    word = '{OP_RD_OUT,    COND_ALWAYS,     UPC_IDLE};
            default:       word = '{OP_NOP,       COND_ALWAYS,     UPC_IDLE};
        endcase
        return word;
    endfunction

    function automatic logic [RNG_W-1:0] xorshift_next(input logic [RNG_W-1:0] s);
        logic [RNG_W-1:0] v;
        v = s;
        v = v ^ (v << SHIFT_A);
        v = v ^ (v >> SHIFT_B);
        v = v ^ (v << SHIFT_C);
        return v;
    endfunction

endpackage

@@ hw/rtl/rpg_sequencer.sv @@
// ----------------------------------------------------------------------------
// rpg_sequencer
// Step counter and microcode table that drive the permutation datapath.
// ----------------------------------------------------------------------------
module rpg_sequencer
    import rpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cond_flags_t flags,
    output seq_ctrl_t   ctrl
);

    upc_t       upc_reg;
    upc_t       upc_next;
    ctrl_word_t word;
    logic       take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    always_comb
    begin
        word = ucode_rom(upc_reg);
        case (word.cond)
            COND_ALWAYS:     take = 1'b1;
            COND_NOT_ACCEPT: take = !flags.accept;
            COND_IS_READ:    take = flags.is_read;
            COND_FILL_MORE:  take = flags.fill_more;
            COND_DIV_MORE:   take = flags.div_more;
            COND_SHUF_MORE:  take = flags.shuf_more;
            default:         take = 1'b1;
        endcase
        upc_next = take ? word.target : upc_t'(upc_reg + 1'b1);
        ctrl.op  = word.op;
        ctrl.upc = upc_reg;
    end

endmodule

@@ hw/rtl/random_permutation_generator_top.sv @@
// ----------------------------------------------------------------------------
// random_permutation_generator_top
// Fisher-Yates shuffle of 0..count-1 driven by a 64-bit xorshift generator,
// with a read port for single entries of the stored permutation.
// ----------------------------------------------------------------------------
// A read transaction is dispatched, issues its store read and then registers its result.
// A generate transaction runs a fill step for each entry, then per swap a
// generator step, the bit-serial remainder unit and three memory steps, all
// stepped by the microcode. One transaction is in work at a time. Reset
// restores the seed, the count of 1024 and the empty status; the store is
// not cleared.
module random_permutation_generator_top
    import rpg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CNT_W-1:0] cfg_write_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    seq_ctrl_t   ctrl;
    cond_flags_t flags;

    logic [CNT_W-1:0] element_count_reg, element_count_next;
    logic [CNT_W-1:0] gen_count_reg, gen_count_next;
    logic             generated_reg, generated_next;
    logic [RNG_W-1:0] rng_reg, rng_next;
    logic [RNG_W-1:0] dividend_reg, dividend_next;
    logic [IDX_W-1:0] rem_reg, rem_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    req_t             req_reg, req_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    status_t          rd_status_reg, rd_status_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic [IDX_W-1:0] perm_mem [MAX_COUNT];
    logic [IDX_W-1:0] rd_a_reg, rd_b_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wr_addr, mem_wr_data;
    logic [IDX_W-1:0] rd_a_addr, rd_b_addr;

    logic             accept;
    logic [CNT_W-1:0] divisor;
    logic [CNT_W-1:0] rem_shift;
    logic [RNG_W-1:0] rng_step;

    rpg_sequencer u_sequencer
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign in_stall  = (ctrl.op != OP_ACCEPT) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign divisor   = CNT_W'({1'b0, idx_reg} + 1'b1);
    assign rem_shift = {rem_reg, dividend_reg[RNG_W-1]};
    assign rng_step  = xorshift_next(rng_reg);

    always_comb
    begin
        flags.accept    = accept;
        flags.is_read   = (req_reg == REQ_READ);
        flags.fill_more = ({1'b0, idx_reg} != CNT_W'(gen_count_reg - 1'b1));
        flags.div_more  = (bit_cnt_reg != {BIT_CNT_W{1'b1}});
        flags.shuf_more = (idx_reg != IDX_W'(1));
    end

    always_comb
    begin
        element_count_next = element_count_reg;
        gen_count_next     = gen_count_reg;
        generated_next     = generated_reg;
        rng_next           = rng_reg;
        dividend_next      = dividend_reg;
        rem_next           = rem_reg;
        bit_cnt_next       = bit_cnt_reg;
        idx_next           = idx_reg;
        req_next           = req_reg;
        pos_next           = pos_reg;
        rd_status_next     = rd_status_reg;
        out_data_next      = out_data_reg;
        out_valid_next     = out_valid_reg && out_stall;
        mem_we             = 1'b0;
        mem_wr_addr        = idx_reg;
        mem_wr_data        = idx_reg;
        rd_a_addr          = idx_reg;
        rd_b_addr          = rem_reg;

        if (cfg_write_en)
        begin
            element_count_next = cfg_write_data;
        end

        case (ctrl.op)
            OP_ACCEPT:
            begin
                if (accept)
                begin
                    req_next = in_data.req_type;
                    pos_next = in_data.position;
                end
            end
            OP_GEN_INIT:
            begin
                if (element_count_reg < CNT_W'(2))
                begin
                    gen_count_next = CNT_W'(2);
                end
                else if (element_count_reg > CNT_W'(MAX_COUNT))
                begin
                    gen_count_next = CNT_W'(MAX_COUNT);
                end
                else
                begin
                    gen_count_next = element_count_reg;
                end
                idx_next = '0;
            end
            OP_FILL:
            begin
                mem_we   = 1'b1;
                idx_next = IDX_W'(idx_reg + 1'b1);
            end
            OP_SHUF_INIT:
            begin
                idx_next = IDX_W'(gen_count_reg - 1'b1);
            end
            OP_RNG:
            begin
                rng_next      = rng_step;
                dividend_next = rng_step;
                rem_next      = '0;
                bit_cnt_next  = '0;
            end
            OP_DIV:
            begin
                if (rem_shift >= divisor)
                begin
                    rem_next = IDX_W'(rem_shift - divisor);
                end
                else
                begin
                    rem_next = rem_shift[IDX_W-1:0];
                end
                dividend_next = {dividend_reg[RNG_W-2:0], 1'b0};
                bit_cnt_next  = BIT_CNT_W'(bit_cnt_reg + 1'b1);
            end
            OP_WRITE_I:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = idx_reg;
                mem_wr_data = rd_b_reg;
            end
            OP_WRITE_J:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = rem_reg;
                mem_wr_data = rd_a_reg;
                idx_next    = IDX_W'(idx_reg - 1'b1);
            end
            OP_GEN_DONE:
            begin
                generated_next = 1'b1;
                out_valid_next = 1'b1;
                out_data_next  = '{entry_value: '0, status: STATUS_OK};
            end
            OP_RD_ISSUE:
            begin
                rd_a_addr = pos_reg;
                if (!generated_reg)
                begin
                    rd_status_next = STATUS_EMPTY;
                end
                else if ({1'b0, pos_reg} >= gen_count_reg)
                begin
                    rd_status_next = STATUS_RANGE;
                end
                else
                begin
                    rd_status_next = STATUS_OK;
                end
            end
            OP_RD_OUT:
            begin
                out_valid_next = 1'b1;
                out_data_next.status      = rd_status_reg;
                out_data_next.entry_value = (rd_status_reg == STATUS_OK) ? rd_a_reg : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= CNT_W'(MAX_COUNT);
            gen_count_reg     <= '0;
            generated_reg     <= 1'b0;
            rng_reg           <= RNG_SEED;
            bit_cnt_reg       <= '0;
            idx_reg           <= '0;
            req_reg           <= REQ_GENERATE;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            element_count_reg <= element_count_next;
            gen_count_reg     <= gen_count_next;
            generated_reg     <= generated_next;
            rng_reg           <= rng_next;
            bit_cnt_reg       <= bit_cnt_next;
            idx_reg           <= idx_next;
            req_reg           <= req_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg  <= dividend_next;
        rem_reg       <= rem_next;
        pos_reg       <= pos_next;
        rd_status_reg <= rd_status_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            perm_mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_a_reg <= perm_mem[rd_a_addr];
        rd_b_reg <= perm_mem[rd_b_addr];
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_dispatch, accept, ctrl.upc == UPC_DISPATCH, "accepted transaction did not reach dispatch")
    `ASSERT_CLK(a_rem_below_divisor, (ctrl.upc != UPC_READ_AB) || ({1'b0, rem_reg} < divisor), "swap index not below divisor")
    `ASSERT_CLK(a_count_in_range, !generated_reg || ((gen_count_reg >= CNT_W'(2)) && (gen_count_reg <= CNT_W'(MAX_COUNT))), "latched count out of range")
    `ASSERT_CLK(a_shuffle_index, (ctrl.upc != UPC_DIV) || (idx_reg != '0), "shuffle index reached zero")

endmodule

@@ sim/random_permutation_generator_top_tb.sv @@
// ----------------------------------------------------------------------------
// random_permutation_generator_top_tb
// Drives generate and read transactions into the permutation generator and
// checks every answer against a shadow shuffle that draws the same xorshift
// sequence. The element count is changed between phases while the block is
// idle, and both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module random_permutation_generator_top_tb;
    import rpg_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_CYCLES = 8;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_write_en = 1'b0;
    logic [CNT_W-1:0] cfg_write_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;

    in_item_t  pending_requests[$];
    out_item_t expected_answers[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    logic      in_fire = 1'b0;
    int        send_gap = 0;
    int        stall_left = 0;
    int        send_idle_odds = 0;
    int        stall_idle_odds = 0;

    logic [IDX_W-1:0] shadow_perm [MAX_COUNT];
    logic [RNG_W-1:0] shadow_rng;
    logic             shadow_generated;
    int               shadow_gen_count;
    logic [CNT_W-1:0] shadow_count_reg;

    random_permutation_generator_top dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data)
    );

    always #5 clk = ~clk;

    function automatic int clamp_count(int value);
        if (value < 2)
        begin
            return 2;
        end
        if (value > MAX_COUNT)
        begin
            return MAX_COUNT;
        end
        return value;
    endfunction

    function automatic void shuffle_identity();
        int               n;
        int               i;
        logic [RNG_W-1:0] r;
        logic [RNG_W-1:0] modulus;
        logic [RNG_W-1:0] j;
        logic [IDX_W-1:0] swap_value;
        n = clamp_count(int'(shadow_count_reg));
        for (i = 0; i < n; i++)
        begin
            shadow_perm[i] = IDX_W'(i);
        end
        for (i = n - 1; i > 0; i--)
        begin
            r = shadow_rng;
            r = r ^ (r << SHIFT_A);
            r = r ^ (r >> SHIFT_B);
            r = r ^ (r << SHIFT_C);
            shadow_rng = r;
            modulus = RNG_W'(i + 1);
            j = r % modulus;
            swap_value = shadow_perm[i];
            shadow_perm[i] = shadow_perm[j];
            shadow_perm[j] = swap_value;
        end
        shadow_gen_count = n;
        shadow_generated = 1'b1;
    endfunction

    function automatic out_item_t answer_request(in_item_t req);
        out_item_t answer;
        answer.entry_value = '0;
        answer.status = STATUS_OK;
        if (req.req_type == REQ_GENERATE)
        begin
            shuffle_identity();
        end
        else if (!shadow_generated)
        begin
            answer.status = STATUS_EMPTY;
        end
        else if (int'(req.position) >= shadow_gen_count)
        begin
            answer.status = STATUS_RANGE;
        end
        else
        begin
            answer.entry_value = shadow_perm[req.position];
        end
        return answer;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d, expected %0d",
                 cycle_count, field, got, want);
        mismatch_count++;
    endtask

    // Prediction on acceptance and checking of each result transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
            shadow_rng = RNG_SEED;
            shadow_generated = 1'b0;
            shadow_gen_count = 0;
            shadow_count_reg = CNT_W'(MAX_COUNT);
        end
        else
        begin
            out_item_t want;
            if (cfg_write_en)
            begin
                shadow_count_reg = cfg_write_data;
            end
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                expected_answers.push_back(answer_request(in_data));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                begin
                    report_mismatch("unexpected transaction, status", out_data.status, 0);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (out_data.entry_value !== want.entry_value)
                    begin
                        report_mismatch("entry_value", out_data.entry_value,
                                        want.entry_value);
                    end
                    if (out_data.status !== want.status)
                    begin
                        report_mismatch("status", out_data.status, want.status);
                    end
                end
            end
        end
    end

    // Request driver: holds a transaction until it is taken, idles in bursts.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (send_idle_odds != 0 && $urandom_range(1, 16) <= send_idle_odds)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 18);
            end
            else if (pending_requests.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data <= pending_requests.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls in bursts.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_idle_odds != 0 && $urandom_range(1, 16) <= stall_idle_odds)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 18);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("random_permutation_generator_top_tb: FAIL");
        $finish;
    end

    function automatic void queue_generate();
        in_item_t item;
        item.req_type = REQ_GENERATE;
        item.position = IDX_W'($urandom_range(0, MAX_COUNT - 1));
        pending_requests.push_back(item);
    endfunction

    function automatic void queue_read(int pos);
        in_item_t item;
        item.req_type = REQ_READ;
        item.position = IDX_W'(pos);
        pending_requests.push_back(item);
    endfunction

    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || in_valid || expected_answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_element_count(int value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= CNT_W'(value);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        int random_left;
        int count_value;
        int active_count;
        int phase_len;
        int k;
        int pick;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_odds = 2;
        stall_idle_odds = 2;

        // Reads before any generate, then a full-size shuffle at the reset count.
        queue_read(0);
        queue_read(MAX_COUNT - 1);
        queue_generate();
        queue_read(0);
        queue_read(MAX_COUNT - 1);
        queue_read(511);
        queue_read(512);
        wait_for_drain();

        // Smallest count, with back-to-back generates.
        write_element_count(2);
        queue_generate();
        queue_generate();
        queue_read(0);
        queue_read(1);
        queue_read(2);
        queue_read(MAX_COUNT - 1);
        wait_for_drain();

        // Counts below the minimum are raised to two.
        write_element_count(0);
        queue_generate();
        queue_read(1);
        queue_read(2);
        wait_for_drain();
        write_element_count(1);
        queue_generate();
        queue_read(2);
        wait_for_drain();

        // A count above the maximum is lowered to the maximum.
        write_element_count((1 << CNT_W) - 1);
        queue_generate();
        queue_read(MAX_COUNT - 1);
        wait_for_drain();

        // A new count leaves reads alone until the next generate.
        write_element_count(3);
        queue_read(MAX_COUNT - 1);
        queue_read(5);
        queue_generate();
        queue_read(3);
        queue_read(0);
        wait_for_drain();

        write_element_count(MAX_COUNT);
        queue_generate();
        queue_read(MAX_COUNT - 1);
        wait_for_drain();

        random_left = 1410;
        while (random_left > 0)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
            begin
                count_value = $urandom_range(0, 1);
            end
            else if (pick == 1)
            begin
                count_value = $urandom_range(65, 200);
            end
            else
            begin
                count_value = $urandom_range(2, 48);
            end
            write_element_count(count_value);
            active_count = clamp_count(count_value);
            if (random_left < 200)
            begin
                send_idle_odds = 0;
                stall_idle_odds = 0;
            end
            else
            begin
                send_idle_odds = $urandom_range(0, 4);
                stall_idle_odds = $urandom_range(0, 4);
            end
            phase_len = $urandom_range(20, 80);
            queue_generate();
            for (k = 0; k < phase_len; k++)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                begin
                    queue_generate();
                end
                else if (pick <= 3)
                begin
                    queue_read($urandom_range(0, MAX_COUNT - 1));
                end
                else
                begin
                    queue_read($urandom_range(0, active_count - 1));
                end
            end
            random_left -= phase_len + 1;
            wait_for_drain();
        end

        wait_for_drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("random_permutation_generator_top_tb: PASS");
        end
        else
        begin
            $display("random_permutation_generator_top_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rpg_pkg.sv
hw/rtl/rpg_sequencer.sv
hw/rtl/random_permutation_generator_top.sv
sim/random_permutation_generator_top_tb.sv
